[hw/rtl/lsted_pkg.sv]
// Shared types and constants for the line-scan track edge detector.
// Used by lsted_core and line_scan_track_edge_detector; no dependencies.
package lsted_pkg;

  localparam int PIX_W   = 12;
  localparam int RUN_W   = 4;
  localparam int IDX_W   = 7;
  localparam int CFG_W   = 12;
  localparam int CIDX_W  = 2;

  localparam logic [PIX_W-1:0] BLACK_THRESHOLD_RST = 12'd1000;
  localparam logic [RUN_W-1:0] RUN_LENGTH_RST      = 4'd3;
  localparam logic [IDX_W-1:0] IMAGE_MIDDLE_RST    = 7'd64;

  typedef enum logic [1:0] {
    STEER_STRAIGHT = 2'd0,
    STEER_LEFT     = 2'd1,
    STEER_RIGHT    = 2'd2,
    STEER_NONE     = 2'd3
  } steer_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_BLACK_THRESHOLD = 2'd0,
    CFG_RUN_LENGTH      = 2'd1,
    CFG_IMAGE_MIDDLE    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] black_threshold;
    logic [RUN_W-1:0] run_length;
    logic [IDX_W-1:0] image_middle;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] left_edge;
    logic [IDX_W-1:0] right_edge;
    logic             found;
    logic [IDX_W-1:0] track_center;
    steer_t           steer;
  } res_t;

endpackage

[hw/rtl/lsted_core.sv]
// Per-line edge search state and end-of-line result computation.
// Depends on lsted_pkg for config and result types.
module lsted_core import lsted_pkg::*; #(
  parameter int MAX_PIXELS = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [PIX_W-1:0] pixel,
  input  logic             last,
  input  cfg_t             cfg,
  output res_t             res
);

  localparam int CapInt = (MAX_PIXELS - 1 > 127) ? 127 : MAX_PIXELS - 1;
  localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(CapInt);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [RUN_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] fe_r, fe_nxt;
  logic             fe_v_r, fe_v_nxt;
  logic [IDX_W-1:0] se_r, se_nxt;
  logic             se_v_r, se_v_nxt;

  logic [RUN_W-1:0] rl;
  logic [RUN_W-1:0] cnt_inc;
  logic [IDX_W:0]   idx_p1;
  logic [IDX_W:0]   start_full;
  logic [IDX_W-1:0] start;
  logic [IDX_W:0]   sum;

  always_comb begin
    rl         = (cfg.run_length == '0) ? RUN_W'(1) : cfg.run_length;
    cnt_inc    = (cnt_r == '1) ? cnt_r : cnt_r + RUN_W'(1);
    idx_p1     = {1'b0, idx_r} + (IDX_W+1)'(1);
    start_full = idx_p1 - (IDX_W+1)'(rl);
    // clamp a run that would start before the line (saturated index)
    start      = (idx_p1 >= (IDX_W+1)'(rl)) ? start_full[IDX_W-1:0] : '0;

    cnt_nxt  = cnt_r;
    fe_nxt   = fe_r;
    fe_v_nxt = fe_v_r;
    se_nxt   = se_r;
    se_v_nxt = se_v_r;
    if (!se_v_r) begin
      if (pixel < cfg.black_threshold) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= rl) begin
          if (!fe_v_r) begin
            fe_nxt   = start;
            fe_v_nxt = 1'b1;
          end else begin
            se_nxt   = start;
            se_v_nxt = 1'b1;
          end
          cnt_nxt = '0;
        end
      end else begin
        cnt_nxt = '0;
      end
    end
    idx_nxt = (idx_r < IDX_CAP) ? idx_r + IDX_W'(1) : idx_r;

    res.found      = fe_v_nxt & se_v_nxt;
    res.left_edge  = res.found ? fe_nxt : '0;
    res.right_edge = res.found ? se_nxt : '0;
    sum            = {1'b0, res.left_edge} + {1'b0, res.right_edge};
    res.track_center = sum[IDX_W:1];
    if (!res.found) begin
      res.steer = STEER_NONE;
    end else if (res.track_center > cfg.image_middle) begin
      res.steer = STEER_LEFT;
    end else if (res.track_center < cfg.image_middle) begin
      res.steer = STEER_RIGHT;
    end else begin
      res.steer = STEER_STRAIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && last)) begin
      // start a fresh line
      idx_r  <= '0;
      cnt_r  <= '0;
      fe_r   <= '0;
      fe_v_r <= 1'b0;
      se_r   <= '0;
      se_v_r <= 1'b0;
    end else if (step_en) begin
      idx_r  <= idx_nxt;
      cnt_r  <= cnt_nxt;
      fe_r   <= fe_nxt;
      fe_v_r <= fe_v_nxt;
      se_r   <= se_nxt;
      se_v_r <= se_v_nxt;
    end
  end

endmodule

[hw/rtl/line_scan_track_edge_detector.sv]
// A pixel word marked last passes from the input register into the output register, which drives out_valid.
// Throughput: one pixel word per cycle; only a word marked last waits in the
// input register, and stalls the input, while the previous result is held by out_stall.
// Reset (rst_n low, synchronous): line state cleared, registers back to
// threshold 1000, run length 3, image middle 64; no clearing pass.
// Depends on lsted_pkg and lsted_core.
module line_scan_track_edge_detector import lsted_pkg::*; #(
  parameter int MAX_PIXELS = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              in_last_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_left_edge,
  output logic [IDX_W-1:0]  out_right_edge,
  output logic              out_found,
  output logic [IDX_W-1:0]  out_track_center,
  output logic [1:0]        out_steer
);

  cfg_t             cfg_r;
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pixel_r;
  logic             s1_last_r;
  logic             s1_adv;
  logic             in_take;
  logic             out_valid_r;
  res_t             out_res_r;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.black_threshold <= BLACK_THRESHOLD_RST;
      cfg_r.run_length      <= RUN_LENGTH_RST;
      cfg_r.image_middle    <= IMAGE_MIDDLE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BLACK_THRESHOLD: cfg_r.black_threshold <= cfg_wdata[PIX_W-1:0];
        CFG_RUN_LENGTH:      cfg_r.run_length      <= cfg_wdata[RUN_W-1:0];
        CFG_IMAGE_MIDDLE:    cfg_r.image_middle    <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the input register unless a result would land on a held one
  assign s1_adv   = s1_valid_r & (~s1_last_r | ~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_adv;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take || s1_adv) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pixel_r <= in_pixel;
      s1_last_r  <= in_last_pixel;
    end
  end

  lsted_core #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(s1_adv),
    .pixel  (s1_pixel_r),
    .last   (s1_last_r),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_edge    = out_res_r.left_edge;
  assign out_right_edge   = out_res_r.right_edge;
  assign out_found        = out_res_r.found;
  assign out_track_center = out_res_r.track_center;
  assign out_steer        = out_res_r.steer;

endmodule
